// ----- design/swps_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swps_pkg: shared constants and types for the sliding window price stats
// Window depth, field widths and sequencer states.
// ----------------------------------------------------------------------------
package swps_pkg;

    localparam int MAX_WINDOW   = 128;
    localparam int PRICE_BITS   = 56;
    localparam int SUM_W        = 63;
    localparam int WIN_W        = 8;
    localparam int CNT_W        = 8;
    localparam int AW           = $clog2(MAX_WINDOW);
    localparam int BIT_W        = $clog2(PRICE_BITS);
    localparam int DIV_W        = $clog2(SUM_W);
    localparam int ENTRY_W      = PRICE_BITS + 1;
    localparam int WINDOW_RESET = 100;

    typedef enum logic [2:0] {
        STATE_IDLE,
        STATE_SUM,
        STATE_SEL,
        STATE_DIV,
        STATE_OUT
    } state_t;

endpackage
`default_nettype wire

// ----- design/sliding_window_price_stats.sv -----
`timescale 1ns / 1ps
`default_nettype none
// sequence: a sale beat starts a walk of the ring for sum and minimum; with a completed
// sale in the window, one select walk follows per price bit (two rounds of them for an
// even completed count), then a serial divide; with none it goes straight to the output
// input: a new sale is taken only in idle, not while the last is worked on, and the
// result waits while an earlier result beat is held; one ring read per cycle in each walk
// reset: aresetn synchronous active low; window empties, window_length = 100
// ----------------------------------------------------------------------------
// sliding_window_price_stats: min, mean, sum and median over a sale window
// Sales go to a ring ram; a sequencer walks the ring for sum and minimum,
// selects the median bit by bit with a counting pass, then divides serially.
// ----------------------------------------------------------------------------
module sliding_window_price_stats (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [swps_pkg::WIN_W-1:0]      cfg_wr_data,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [swps_pkg::PRICE_BITS-1:0] s_sale_price,
    input  wire logic                            s_sale_completed,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic                                 m_stats_valid,
    output logic [swps_pkg::PRICE_BITS-1:0]      m_floor_price,
    output logic [swps_pkg::PRICE_BITS-1:0]      m_average_price,
    output logic [swps_pkg::PRICE_BITS-1:0]      m_median_price,
    output logic [swps_pkg::SUM_W-1:0]           m_total_volume,
    output logic [swps_pkg::CNT_W-1:0]           m_completed_total
);

    localparam int PB = swps_pkg::PRICE_BITS;
    localparam int CW = swps_pkg::CNT_W;
    localparam int AW = swps_pkg::AW;
    localparam int SW = swps_pkg::SUM_W;
    localparam int BW = swps_pkg::BIT_W;
    localparam int DW = swps_pkg::DIV_W;

    swps_pkg::state_t state_reg, state_next;

    logic [swps_pkg::WIN_W-1:0] win_len_reg;
    logic [AW-1:0]  wptr_reg, wptr_next;
    logic [CW-1:0]  fill_reg, fill_next;
    logic [CW-1:0]  rd_idx_reg, rd_idx_next;
    logic           rd_vld_reg, rd_vld_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [SW-1:0]  sum_reg, sum_next;
    logic [PB-1:0]  min_reg, min_next;
    logic [BW-1:0]  bit_reg, bit_next;
    logic [CW-1:0]  krem_reg, krem_next;
    logic [CW-1:0]  sel_cnt_reg, sel_cnt_next;
    logic [PB-1:0]  prefix_reg, prefix_next;
    logic           second_reg, second_next;
    logic [PB-1:0]  med_a_reg, med_a_next;
    logic [PB-1:0]  med_reg, med_next;
    logic [DW-1:0]  div_cnt_reg, div_cnt_next;
    logic [SW-1:0]  div_reg, div_next;
    logic [CW-1:0]  rem_reg, rem_next;

    logic           m_valid_reg, m_valid_next;
    logic           o_stats_reg, o_stats_next;
    logic [PB-1:0]  o_floor_reg, o_floor_next;
    logic [PB-1:0]  o_avg_reg, o_avg_next;
    logic [PB-1:0]  o_med_reg, o_med_next;
    logic [SW-1:0]  o_sum_reg, o_sum_next;
    logic [CW-1:0]  o_cnt_reg, o_cnt_next;

    logic                        accept;
    logic [CW-1:0]               eff_win;
    logic [CW:0]                 fill_inc;
    logic [AW:0]                 addr_sum;
    logic [AW-1:0]               rd_addr;
    logic [swps_pkg::ENTRY_W-1:0] rd_data;
    logic [PB-1:0]               rd_price;
    logic                        rd_comp;
    logic                        issue;
    logic                        pass_end;
    logic [PB-1:0]               himask;
    logic [PB-1:0]               prefix_done;
    logic [CW:0]                 trial;
    logic                        trial_ge;
    logic [PB-1:0]               even_med;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == swps_pkg::STATE_IDLE);
    assign rd_price = rd_data[PB-1:0];
    assign rd_comp  = rd_data[PB];

    // effective window length: zero acts as one, saturate at the ring depth
    always_comb begin
        if (win_len_reg == '0) begin
            eff_win = CW'(1);
        end else if (32'(win_len_reg) > swps_pkg::MAX_WINDOW) begin
            eff_win = CW'(swps_pkg::MAX_WINDOW);
        end else begin
            eff_win = CW'(win_len_reg);
        end
    end

    assign fill_inc = {1'b0, fill_reg} + (CW+1)'(1);

    // ring address, newest entry first
    assign addr_sum = (AW+1)'(wptr_reg) + (AW+1)'(swps_pkg::MAX_WINDOW - 1)
                    - (AW+1)'(rd_idx_reg);
    assign rd_addr  = (32'(addr_sum) >= swps_pkg::MAX_WINDOW)
                    ? AW'(addr_sum - (AW+1)'(swps_pkg::MAX_WINDOW)) : AW'(addr_sum);

    swps_ram #(
        .WIDTH (swps_pkg::ENTRY_W),
        .DEPTH (swps_pkg::MAX_WINDOW)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (accept),
        .wr_addr (wptr_reg),
        .wr_data ({s_sale_completed, s_sale_price}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // pass bookkeeping shared by the sum and select walks
    assign issue    = (rd_idx_reg < fill_reg);
    assign pass_end = (rd_idx_reg == fill_reg) && !rd_vld_reg;

    // selection helpers
    assign himask      = {PB{1'b1}} << bit_reg;
    assign prefix_done = (krem_reg < sel_cnt_reg) ? prefix_reg
                       : (prefix_reg | (PB'(1) << bit_reg));
    assign even_med    = (med_a_reg >> 1) + (prefix_done >> 1)
                       + PB'(med_a_reg[0] & prefix_done[0]);

    // divider trial subtract
    assign trial    = {rem_reg, div_reg[SW-1]};
    assign trial_ge = (trial >= {1'b0, cnt_reg});

    // sequencer next state and datapath
    always_comb begin
        state_next   = state_reg;
        wptr_next    = wptr_reg;
        fill_next    = fill_reg;
        rd_idx_next  = rd_idx_reg;
        rd_vld_next  = 1'b0;
        cnt_next     = cnt_reg;
        sum_next     = sum_reg;
        min_next     = min_reg;
        bit_next     = bit_reg;
        krem_next    = krem_reg;
        sel_cnt_next = sel_cnt_reg;
        prefix_next  = prefix_reg;
        second_next  = second_reg;
        med_a_next   = med_a_reg;
        med_next     = med_reg;
        div_cnt_next = div_cnt_reg;
        div_next     = div_reg;
        rem_next     = rem_reg;
        m_valid_next = m_valid_reg && !m_ready;
        o_stats_next = o_stats_reg;
        o_floor_next = o_floor_reg;
        o_avg_next   = o_avg_reg;
        o_med_next   = o_med_reg;
        o_sum_next   = o_sum_reg;
        o_cnt_next   = o_cnt_reg;

        case (state_reg)
            swps_pkg::STATE_IDLE: begin
                if (accept) begin
                    wptr_next   = (32'(wptr_reg) == swps_pkg::MAX_WINDOW - 1)
                                ? '0 : wptr_reg + AW'(1);
                    fill_next   = (fill_inc > {1'b0, eff_win}) ? eff_win : CW'(fill_inc);
                    rd_idx_next = '0;
                    cnt_next    = '0;
                    sum_next    = '0;
                    min_next    = '0;
                    state_next  = swps_pkg::STATE_SUM;
                end
            end
            swps_pkg::STATE_SUM: begin
                rd_vld_next = issue;
                rd_idx_next = rd_idx_reg + CW'(issue);
                if (rd_vld_reg && rd_comp) begin
                    cnt_next = cnt_reg + CW'(1);
                    sum_next = sum_reg + SW'(rd_price);
                    if (cnt_reg == '0 || rd_price < min_reg) begin
                        min_next = rd_price;
                    end
                end
                if (pass_end) begin
                    rd_idx_next  = '0;
                    sel_cnt_next = '0;
                    prefix_next  = '0;
                    second_next  = 1'b0;
                    bit_next     = BW'(PB - 1);
                    krem_next    = cnt_reg[0] ? (cnt_reg >> 1) : ((cnt_reg >> 1) - CW'(1));
                    state_next   = (cnt_reg == '0) ? swps_pkg::STATE_OUT
                                                   : swps_pkg::STATE_SEL;
                end
            end
            swps_pkg::STATE_SEL: begin
                rd_vld_next = issue;
                rd_idx_next = rd_idx_reg + CW'(issue);
                if (rd_vld_reg && rd_comp && ((rd_price & himask) == prefix_reg)) begin
                    sel_cnt_next = sel_cnt_reg + CW'(1);
                end
                if (pass_end) begin
                    rd_idx_next  = '0;
                    sel_cnt_next = '0;
                    prefix_next  = prefix_done;
                    if (krem_reg >= sel_cnt_reg) begin
                        krem_next = krem_reg - sel_cnt_reg;
                    end
                    if (bit_reg == '0) begin
                        bit_next = BW'(PB - 1);
                        if (cnt_reg[0]) begin
                            med_next   = prefix_done;
                            state_next = swps_pkg::STATE_DIV;
                        end else if (!second_reg) begin
                            med_a_next  = prefix_done;
                            second_next = 1'b1;
                            prefix_next = '0;
                            krem_next   = cnt_reg >> 1;
                        end else begin
                            med_next   = even_med;
                            state_next = swps_pkg::STATE_DIV;
                        end
                        div_next     = sum_reg;
                        rem_next     = '0;
                        div_cnt_next = DW'(SW - 1);
                    end else begin
                        bit_next = bit_reg - BW'(1);
                    end
                end
            end
            swps_pkg::STATE_DIV: begin
                rem_next     = trial_ge ? CW'(trial - {1'b0, cnt_reg}) : CW'(trial);
                div_next     = {div_reg[SW-2:0], trial_ge};
                div_cnt_next = div_cnt_reg - DW'(1);
                if (div_cnt_reg == '0) begin
                    state_next = swps_pkg::STATE_OUT;
                end
            end
            swps_pkg::STATE_OUT: begin
                if (!m_valid_reg) begin
                    m_valid_next = 1'b1;
                    o_cnt_next   = cnt_reg;
                    if (cnt_reg == '0) begin
                        o_stats_next = 1'b0;
                        o_floor_next = '0;
                        o_avg_next   = '0;
                        o_med_next   = '0;
                        o_sum_next   = '0;
                    end else begin
                        o_stats_next = 1'b1;
                        o_floor_next = min_reg;
                        o_avg_next   = div_reg[PB-1:0];
                        o_med_next   = med_reg;
                        o_sum_next   = sum_reg;
                    end
                    state_next = swps_pkg::STATE_IDLE;
                end
            end
            default: begin
                state_next = swps_pkg::STATE_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= swps_pkg::STATE_IDLE;
            m_valid_reg <= 1'b0;
            wptr_reg    <= '0;
            fill_reg    <= '0;
            win_len_reg <= swps_pkg::WIN_W'(swps_pkg::WINDOW_RESET);
            rd_vld_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            wptr_reg    <= wptr_next;
            fill_reg    <= fill_next;
            rd_vld_reg  <= rd_vld_next;
            if (cfg_wr_en) begin
                win_len_reg <= cfg_wr_data;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        rd_idx_reg  <= rd_idx_next;
        cnt_reg     <= cnt_next;
        sum_reg     <= sum_next;
        min_reg     <= min_next;
        bit_reg     <= bit_next;
        krem_reg    <= krem_next;
        sel_cnt_reg <= sel_cnt_next;
        prefix_reg  <= prefix_next;
        second_reg  <= second_next;
        med_a_reg   <= med_a_next;
        med_reg     <= med_next;
        div_cnt_reg <= div_cnt_next;
        div_reg     <= div_next;
        rem_reg     <= rem_next;
        o_stats_reg <= o_stats_next;
        o_floor_reg <= o_floor_next;
        o_avg_reg   <= o_avg_next;
        o_med_reg   <= o_med_next;
        o_sum_reg   <= o_sum_next;
        o_cnt_reg   <= o_cnt_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_stats_valid     = o_stats_reg;
    assign m_floor_price     = o_floor_reg;
    assign m_average_price   = o_avg_reg;
    assign m_median_price    = o_med_reg;
    assign m_total_volume    = o_sum_reg;
    assign m_completed_total = o_cnt_reg;

endmodule
`default_nettype wire

// ----- design/swps_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swps_ram: generic simple dual port ram
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module swps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// ----- design/swps_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swps_checker: port level checks for the sliding window price stats
// Watches the handshakes and result fields of the top level.
// ----------------------------------------------------------------------------
module swps_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_valid,
    input wire logic                            s_ready,
    input wire logic                            m_valid,
    input wire logic                            m_ready,
    input wire logic                            m_stats_valid,
    input wire logic [swps_pkg::PRICE_BITS-1:0] m_floor_price,
    input wire logic [swps_pkg::PRICE_BITS-1:0] m_median_price,
    input wire logic [swps_pkg::SUM_W-1:0]      m_total_volume,
    input wire logic [swps_pkg::CNT_W-1:0]      m_completed_total
);

    // a sale beat blocks the input while it is worked on
    a_busy_after_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after a sale beat");

    // result beat holds until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result beat dropped before taken");

    // no completed sale in the window gives zero fields
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_stats_valid |-> m_floor_price == '0 && m_median_price == '0
            && m_total_volume == '0 && m_completed_total == '0)
        else $error("nonzero fields with no completed sale");

    // minimum never exceeds median, and count agrees with valid
    a_floor_le_median: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_stats_valid |-> m_floor_price <= m_median_price
            && m_completed_total != '0)
        else $error("floor above median or zero count");

endmodule

bind sliding_window_price_stats swps_checker u_swps_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_stats_valid     (m_stats_valid),
    .m_floor_price     (m_floor_price),
    .m_median_price    (m_median_price),
    .m_total_volume    (m_total_volume),
    .m_completed_total (m_completed_total)
);
`default_nettype wire
